// ----- design/c2d_pkg.sv -----
// package for the fixed-point convolution block: sizes, store depths, opcodes, states
// used by conv2d_fixed_point_relu
`timescale 1ns / 1ps
package c2d_pkg;
    localparam int MAX_IN_CH  = 16;
    localparam int MAX_OUT_CH = 16;
    localparam int MAX_SIZE   = 32;
    localparam int MAX_KERNEL = 5;
    localparam int Q_SHIFT    = 6;

    localparam int FEAT_DEPTH = MAX_IN_CH * MAX_SIZE * MAX_SIZE;
    localparam int WGT_DEPTH  = MAX_OUT_CH * MAX_IN_CH * MAX_KERNEL * MAX_KERNEL;
    localparam int FEAT_AW    = $clog2(FEAT_DEPTH);
    localparam int WGT_AW     = $clog2(WGT_DEPTH);
    localparam int BIAS_AW    = $clog2(MAX_OUT_CH);

    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_BIAS   = 2'd2,
        OP_CALC   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_IN_CH    = 3'd0,
        CFG_OUT_CH   = 3'd1,
        CFG_KERNEL   = 3'd2,
        CFG_STRIDE   = 3'd3,
        CFG_PADDING  = 3'd4,
        CFG_IN_SIZE  = 3'd5,
        CFG_OUT_SIZE = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } state_t;
endpackage

// ----- design/c2d_ram.sv -----
// generic single-port-write, single-port-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps
module c2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/conv2d_fixed_point_relu.sv -----
// Q6 fixed-point 2-D convolution with zero padding, stride, ReLU and saturation.
// Load transfers (pixel, weight, bias) are written into their RAMs and give no
// result. A compute transfer walks every input channel and kernel tap, one stored
// product a cycle through the feature and weight RAMs, into a multiply-accumulate
// loop started from the bias. Out-of-range requests give status 1 with value 0.
// A finished result sits in the output register while the next item may be
// accepted; a later compute holds in its last state until that register is free.
// No clearing pass after reset.
// depends on c2d_pkg and c2d_ram
`timescale 1ns / 1ps
module conv2d_fixed_point_relu
    import c2d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [5:0]  cfg_wdata,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: opcode[1:0], out_channel[5:2], in_channel[9:6], row[14:10], col[19:15],
    //        value[51:20], zero fill[55:52]
    input  logic [55:0] s_tdata,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: res_value[14:0], res_channel[18:15], res_row[23:19], res_col[28:24],
    //        res_status[29], zero fill[31:30]
    output logic [31:0] m_tdata
);
    // configuration registers
    logic [4:0] in_ch_reg, out_ch_reg;
    logic [2:0] ksz_reg, stride_reg;
    logic [1:0] pad_reg;
    logic [5:0] in_size_reg, out_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ch_reg    <= 5'd1;
            out_ch_reg   <= 5'd1;
            ksz_reg      <= 3'd3;
            stride_reg   <= 3'd1;
            pad_reg      <= 2'd1;
            in_size_reg  <= 6'd16;
            out_size_reg <= 6'd16;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_IN_CH:    in_ch_reg    <= cfg_wdata[4:0];
                CFG_OUT_CH:   out_ch_reg   <= cfg_wdata[4:0];
                CFG_KERNEL:   ksz_reg      <= cfg_wdata[2:0];
                CFG_STRIDE:   stride_reg   <= cfg_wdata[2:0];
                CFG_PADDING:  pad_reg      <= cfg_wdata[1:0];
                CFG_IN_SIZE:  in_size_reg  <= cfg_wdata[5:0];
                CFG_OUT_SIZE: out_size_reg <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    // capped loop limits
    logic [4:0] nin;
    logic [2:0] ks;
    logic [5:0] sz;
    assign nin = (in_ch_reg > 5'(MAX_IN_CH)) ? 5'(MAX_IN_CH) : in_ch_reg;
    assign ks  = (ksz_reg > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : ksz_reg;
    assign sz  = (in_size_reg > 6'(MAX_SIZE)) ? 6'(MAX_SIZE) : in_size_reg;

    // input field unpacking
    op_t          in_op;
    logic [3:0]   in_oc, in_ic;
    logic [4:0]   in_row, in_col;
    logic [31:0]  in_val;
    assign in_op  = op_t'(s_tdata[1:0]);
    assign in_oc  = s_tdata[5:2];
    assign in_ic  = s_tdata[9:6];
    assign in_row = s_tdata[14:10];
    assign in_col = s_tdata[19:15];
    assign in_val = s_tdata[51:20];

    state_t state_reg, state_next;
    logic   s_fire, m_fire;
    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    // output register
    logic        ovalid_reg;
    logic [31:0] odata_reg;
    logic        out_load;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    // the finished result moves out once the output register is free or draining
    assign out_load = (state_reg == ST_DONE) && (!ovalid_reg || m_tready);

    // request registers
    logic [3:0] oc_reg;
    logic [4:0] row_reg, col_reg;
    logic       bad_reg;

    // walk counters
    logic [4:0] j_reg;
    logic [2:0] kr_reg, kc_reg;

    // ready whenever idle; the output register parts the two sides
    assign s_tready = (state_reg == ST_IDLE);

    // window position of the current tap, signed, enough bits for 31*7+4
    logic signed [8:0] pr, pc;
    logic              tap_ok, last_tap;
    assign pr = $signed({1'b0, 8'(row_reg * stride_reg) + 8'(kr_reg)}) -
                $signed({7'd0, pad_reg});
    assign pc = $signed({1'b0, 8'(col_reg * stride_reg) + 8'(kc_reg)}) -
                $signed({7'd0, pad_reg});
    assign tap_ok = (pr >= 0) && (pr < $signed({3'd0, sz})) &&
                    (pc >= 0) && (pc < $signed({3'd0, sz}));
    assign last_tap = (kc_reg == ks - 3'd1) && (kr_reg == ks - 3'd1) &&
                      (j_reg == nin - 5'd1);

    // RAM addresses
    logic [FEAT_AW-1:0] f_waddr, f_raddr;
    logic [WGT_AW-1:0]  w_waddr, w_raddr;
    logic               f_we, w_we, b_we;
    logic [15:0]        f_rdata, w_rdata;
    logic [31:0]        b_rdata;

    assign f_waddr = {in_ic, in_row, in_col};
    assign f_raddr = {j_reg[3:0], pr[4:0], pc[4:0]};
    assign w_waddr = WGT_AW'((({9'd0, in_oc} * 13'(MAX_IN_CH) + {9'd0, in_ic})
                      * 13'(MAX_KERNEL) + {10'd0, in_row[2:0]}) * 13'(MAX_KERNEL)
                      + {10'd0, in_col[2:0]});
    assign w_raddr = WGT_AW'((({9'd0, oc_reg} * 13'(MAX_IN_CH) + {8'd0, j_reg})
                      * 13'(MAX_KERNEL) + {10'd0, kr_reg}) * 13'(MAX_KERNEL)
                      + {10'd0, kc_reg});
    assign f_we = s_fire && in_op == OP_PIXEL;
    assign w_we = s_fire && in_op == OP_WEIGHT &&
                  in_row < 5'(MAX_KERNEL) && in_col < 5'(MAX_KERNEL);
    assign b_we = s_fire && in_op == OP_BIAS;

    c2d_ram #(.WIDTH(16), .DEPTH(FEAT_DEPTH)) u_feat (
        .aclk(aclk), .we(f_we), .waddr(f_waddr), .wdata(in_val[15:0]),
        .raddr(f_raddr), .rdata(f_rdata));
    c2d_ram #(.WIDTH(16), .DEPTH(WGT_DEPTH)) u_wgt (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(in_val[15:0]),
        .raddr(w_raddr), .rdata(w_rdata));
    // bias read is issued at the accepting edge of the compute transfer
    c2d_ram #(.WIDTH(32), .DEPTH(MAX_OUT_CH)) u_bias (
        .aclk(aclk), .we(b_we), .waddr(in_oc), .wdata(in_val),
        .raddr(in_oc), .rdata(b_rdata));

    // pipeline: read valid, product register, accumulator
    logic               rd_v_reg, prod_v_reg, bias_v_reg;
    logic signed [31:0] prod_reg;
    logic signed [40:0] acc_reg;
    logic signed [31:0] prod_full;
    logic signed [31:0] prod_q;
    assign prod_full = $signed(f_rdata) * $signed(w_rdata);
    // truncating divide by 64: add 63 when negative before shifting
    assign prod_q = (prod_reg + (prod_reg[31] ? 32'sd63 : 32'sd0)) >>> Q_SHIFT;

    logic walk_go;
    always_comb begin
        state_next = state_reg;
        walk_go    = 1'b0;
        unique case (state_reg)
            ST_IDLE: if (s_fire && in_op == OP_CALC) begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (bad_reg || nin == 5'd0 || ks == 3'd0) begin
                    state_next = ST_DRAIN;
                end else begin
                    walk_go = 1'b1;
                    if (last_tap) state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: if (!rd_v_reg && !prod_v_reg) begin
                state_next = ST_DONE;
            end
            ST_DONE: if (out_load) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
            bias_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_v_reg   <= walk_go && tap_ok;
            prod_v_reg <= rd_v_reg;
            bias_v_reg <= (state_reg == ST_IDLE) && s_fire && in_op == OP_CALC;
            if (out_load) begin
                ovalid_reg <= 1'b1;
            end else if (m_fire) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // request capture, counters, datapath
    always_ff @(posedge aclk) begin
        if (s_fire && in_op == OP_CALC) begin
            oc_reg  <= in_oc;
            row_reg <= in_row;
            col_reg <= in_col;
            bad_reg <= ({1'b0, in_oc} >= out_ch_reg) ||
                       ({1'b0, in_row} >= out_size_reg) ||
                       ({1'b0, in_col} >= out_size_reg);
            j_reg   <= 5'd0;
            kr_reg  <= 3'd0;
            kc_reg  <= 3'd0;
        end else if (walk_go) begin
            if (kc_reg == ks - 3'd1) begin
                kc_reg <= 3'd0;
                if (kr_reg == ks - 3'd1) begin
                    kr_reg <= 3'd0;
                    j_reg  <= j_reg + 5'd1;
                end else begin
                    kr_reg <= kr_reg + 3'd1;
                end
            end else begin
                kc_reg <= kc_reg + 3'd1;
            end
        end
        prod_reg <= prod_full;
        if (bias_v_reg) begin
            acc_reg <= 41'(signed'(b_rdata));
        end else if (prod_v_reg) begin
            acc_reg <= acc_reg + 41'(prod_q);
        end
        if (out_load) begin
            odata_reg[31:30] <= 2'd0;
            odata_reg[29]    <= bad_reg;
            odata_reg[28:24] <= col_reg;
            odata_reg[23:19] <= row_reg;
            odata_reg[18:15] <= oc_reg;
            if (bad_reg || acc_reg < 0) begin
                odata_reg[14:0] <= 15'd0;
            end else if (acc_reg > 41'sd32767) begin
                odata_reg[14:0] <= 15'h7FFF;
            end else begin
                odata_reg[14:0] <= acc_reg[14:0];
            end
        end
    end

    // no transfer accepted while a compute is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input accepted during compute");
    // a result appears only after the done state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result without compute");
    // products only flow while walking or draining
    assert property (@(posedge aclk) disable iff (!aresetn)
        prod_v_reg |-> (state_reg == ST_WALK || state_reg == ST_DRAIN))
        else $error("stray product");
endmodule
